// ===== hdl/scms_pkg.sv =====
// scms_pkg: op codes, status codes and the controller/datapath command and
// status words for the sorted counting multiset.
// No dependencies.
`default_nettype none

package scms_pkg;

  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_DEC  = 2'd1;
  localparam logic [1:0] OP_DUMP = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_SAT    = 2'd3;

  typedef struct packed {
    logic capture;
    logic exec;
    logic dump_step;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       out_free;
    logic       occ_zero;
    logic       rem_one;
  } sts_t;

endpackage

`default_nettype wire

// ===== hdl/scms_ctrl.sv =====
// scms_ctrl: sequencer for the multiset; accepts an input word, runs the
// update or streams the dump. Depends on scms_pkg.
`default_nettype none

module scms_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire scms_pkg::sts_t sts,
  output scms_pkg::cmd_t     cmd
);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_DUMP} state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.out_free) begin
          if (sts.op == scms_pkg::OP_DUMP && !sts.occ_zero) begin
            cmd.dump_step = 1'b1;
            state_next    = sts.rem_one ? S_IDLE : S_DUMP;
          end else begin
            cmd.exec   = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      S_DUMP: begin
        if (sts.out_free) begin
          cmd.dump_step = 1'b1;
          if (sts.rem_one) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/scms_dp.sv =====
// scms_dp: sorted key/count table with parallel compare, shift insert and
// remove, dump rotation, and the output word register. Depends on scms_pkg.
`default_nettype none

module scms_dp #(
  parameter int TABLE_DEPTH = 16,
  parameter int KEY_BITS    = 16,
  parameter int COUNT_BITS  = 16
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic [1:0]     in_op,
  input  wire logic [15:0]    in_size,
  input  wire logic [15:0]    in_amt,
  input  wire scms_pkg::cmd_t cmd,
  output scms_pkg::sts_t      sts,
  input  wire logic           out_ready,
  output logic                out_valid,
  output logic [1:0]          status,
  output logic [15:0]         entry_size,
  output logic [15:0]         entry_count,
  output logic                table_empty,
  output logic                last
);

  localparam int OW = $clog2(TABLE_DEPTH + 1);
  localparam int SW = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;
  localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

  logic [KEY_BITS-1:0]   sizes       [TABLE_DEPTH];
  logic [COUNT_BITS-1:0] counts      [TABLE_DEPTH];
  logic [KEY_BITS-1:0]   sizes_next  [TABLE_DEPTH];
  logic [COUNT_BITS-1:0] counts_next [TABLE_DEPTH];
  logic [OW-1:0]         occ;
  logic [OW-1:0]         rem;

  logic [1:0]             opr;
  logic [KEY_BITS-1:0]    keyr;
  logic [15:0]            amtr;
  logic [TABLE_DEPTH-1:0] ltv;
  logic [TABLE_DEPTH-1:0] eqv;

  logic [KEY_BITS-1:0]    key_in;
  logic [TABLE_DEPTH-1:0] lt_in;
  logic [TABLE_DEPTH-1:0] eq_in;

  logic [COUNT_BITS-1:0] hitcnt;
  logic                  hit;
  logic                  full;
  logic                  amt_zero;
  logic [SW-1:0]         sum;
  logic                  sat;
  logic [COUNT_BITS-1:0] newc;
  logic                  do_upd;
  logic                  do_ins;
  logic                  do_dec;
  logic                  do_rem;
  logic [1:0]            res_st;
  logic [COUNT_BITS-1:0] res_cnt;
  logic                  res_empty;
  logic                  out_free;

  assign key_in = KEY_BITS'(in_size);

  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      lt_in[i] = (OW'(i) < occ) && (sizes[i] < key_in);
      eq_in[i] = (OW'(i) < occ) && (sizes[i] == key_in);
    end
  end

  always_comb begin
    hitcnt = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      hitcnt = hitcnt | (counts[i] & {COUNT_BITS{eqv[i]}});
    end
  end

  assign hit      = |eqv;
  assign full     = (occ == OW'(TABLE_DEPTH));
  assign amt_zero = (amtr == 16'd0);
  assign sum      = SW'(hitcnt) + SW'(amtr);
  assign sat      = (sum > SW'(CMAX));
  assign newc     = sat ? CMAX : sum[COUNT_BITS-1:0];

  assign do_upd = (opr == scms_pkg::OP_ADD) && !amt_zero && hit;
  assign do_ins = (opr == scms_pkg::OP_ADD) && !amt_zero && !hit && !full;
  assign do_dec = (opr == scms_pkg::OP_DEC) && hit && (hitcnt > COUNT_BITS'(1));
  assign do_rem = (opr == scms_pkg::OP_DEC) && hit && (hitcnt <= COUNT_BITS'(1));

  always_comb begin
    res_st    = scms_pkg::ST_OK;
    res_cnt   = '0;
    res_empty = 1'b0;
    case (opr)
      scms_pkg::OP_ADD: begin
        if (amt_zero) begin
          res_cnt = hitcnt;
        end else if (!hit && full) begin
          res_st = scms_pkg::ST_FULL;
        end else begin
          res_st  = sat ? scms_pkg::ST_SAT : scms_pkg::ST_OK;
          res_cnt = newc;
        end
      end
      scms_pkg::OP_DEC: begin
        if (!hit) begin
          res_st = scms_pkg::ST_ABSENT;
        end else if (do_dec) begin
          res_cnt = hitcnt - COUNT_BITS'(1);
        end
      end
      scms_pkg::OP_DUMP: res_empty = 1'b1;
      default: res_cnt = '0;
    endcase
  end

  // cell i moves up from i+1 (rotate, remove) or down from i-1 (insert)
  always_comb begin
    sizes_next  = sizes;
    counts_next = counts;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (cmd.dump_step) begin
        if (OW'(i) == occ - OW'(1)) begin
          sizes_next[i]  = sizes[0];
          counts_next[i] = counts[0];
        end else if (OW'(i) < occ) begin
          sizes_next[i]  = sizes[(i < TABLE_DEPTH - 1) ? i + 1 : i];
          counts_next[i] = counts[(i < TABLE_DEPTH - 1) ? i + 1 : i];
        end
      end else if (cmd.exec) begin
        if (do_ins && !ltv[i]) begin
          if (i == 0 || ltv[(i > 0) ? i - 1 : i]) begin
            sizes_next[i]  = keyr;
            counts_next[i] = newc;
          end else begin
            sizes_next[i]  = sizes[(i > 0) ? i - 1 : i];
            counts_next[i] = counts[(i > 0) ? i - 1 : i];
          end
        end else if (do_upd && eqv[i]) begin
          counts_next[i] = newc;
        end else if (do_dec && eqv[i]) begin
          counts_next[i] = hitcnt - COUNT_BITS'(1);
        end else if (do_rem && !ltv[i]) begin
          sizes_next[i]  = sizes[(i < TABLE_DEPTH - 1) ? i + 1 : i];
          counts_next[i] = counts[(i < TABLE_DEPTH - 1) ? i + 1 : i];
        end
      end
    end
  end

  assign out_free = !out_valid || out_ready;

  always_comb begin
    sts          = '0;
    sts.op       = opr;
    sts.out_free = out_free;
    sts.occ_zero = (occ == '0);
    sts.rem_one  = (rem == OW'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.exec && do_ins) begin
        occ <= occ + OW'(1);
      end else if (cmd.exec && do_rem) begin
        occ <= occ - OW'(1);
      end
      if (cmd.exec || cmd.dump_step) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    sizes  <= sizes_next;
    counts <= counts_next;
    if (cmd.capture) begin
      opr  <= in_op;
      keyr <= key_in;
      amtr <= in_amt;
      ltv  <= lt_in;
      eqv  <= eq_in;
      rem  <= occ;
    end else if (cmd.dump_step) begin
      rem <= rem - OW'(1);
    end
    if (cmd.dump_step) begin
      status      <= scms_pkg::ST_OK;
      entry_size  <= 16'(sizes[0]);
      entry_count <= 16'(counts[0]);
      table_empty <= 1'b0;
      last        <= (rem == OW'(1));
    end else if (cmd.exec) begin
      status      <= res_st;
      entry_size  <= 16'd0;
      entry_count <= 16'(res_cnt);
      table_empty <= res_empty;
      last        <= 1'b1;
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= OW'(TABLE_DEPTH))
    else $error("occupancy above table depth");

  a_single_hit: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |-> $onehot0(eqv))
    else $error("key matched in more than one entry");

  a_sorted: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |-> ((ltv & (ltv + TABLE_DEPTH'(1))) == '0))
    else $error("less-than vector is not a prefix, table out of order");

  a_dump_count: assert property (@(posedge clk) disable iff (rst)
    cmd.dump_step |-> (rem != '0))
    else $error("dump step with no entries left");

endmodule

`default_nettype wire

// ===== hdl/sorted_counting_multiset_core.sv =====
// sorted_counting_multiset_core: top level of the sorted counting multiset.
// Depends on scms_pkg, scms_ctrl and scms_dp.
//
//   channel  handshake              words
//   in       in_valid / in_ready    op, key_size, add_count
//   out      out_valid / out_ready  status, entry_size, entry_count,
//                                   table_empty, last
//
// Add, decrease and op 3 compare in the accept cycle, then update the table
// and load the result register once the output is free. A dump emits one
// word per cycle after the accept cycle unless stalled, occupancy words in
// all (one when empty). rst is synchronous and empties the table. A stalled
// output register holds off the next update or dump step; one more input
// word is taken meanwhile, then input waits until the word is out.
`default_nettype none

module sorted_counting_multiset_core #(
  parameter int TABLE_DEPTH = 16,
  parameter int KEY_BITS    = 16,
  parameter int COUNT_BITS  = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  op,
  input  wire logic [15:0] key_size,
  input  wire logic [15:0] add_count,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic [15:0]      entry_size,
  output logic [15:0]      entry_count,
  output logic             table_empty,
  output logic             last
);

  scms_pkg::cmd_t cmd;
  scms_pkg::sts_t sts;

  scms_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  scms_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BITS    (KEY_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .in_op       (op),
    .in_size     (key_size),
    .in_amt      (add_count),
    .cmd         (cmd),
    .sts         (sts),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .status      (status),
    .entry_size  (entry_size),
    .entry_count (entry_count),
    .table_empty (table_empty),
    .last        (last)
  );

endmodule

`default_nettype wire
